[design/maf_pkg.sv]
// Shared types and constants of the moving average filter.
package maf_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int AVG_W     = 32;
    localparam int SUM_W     = 40;
    localparam int CFG_W     = 9;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = SUM_W / DIGIT_W;
    localparam int CARRY_W   = 2;
    localparam int ACC_CNT_W = $clog2(DIGITS + 1);
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
    localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

    typedef struct packed {
        logic start;
        logic clear;
        logic subtract;
    } acc_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

[design/maf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module maf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when both ports hit the same entry.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

[design/maf_acc.sv]
// Digit-serial running sum: adds the new sample and, when subtract is set, subtracts the retired one.
module maf_acc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  maf_pkg::acc_ctrl_t           ctrl,
    input  logic [maf_pkg::SAMPLE_W-1:0] sample,
    input  logic [maf_pkg::SAMPLE_W-1:0] old_sample,
    output maf_pkg::unit_stat_t          stat,
    output logic [maf_pkg::SUM_W-1:0]    sum
);

    import maf_pkg::*;

    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [SUM_W-1:0]           a_reg, a_next;
    logic [SUM_W-1:0]           b_reg, b_next;
    logic [CARRY_W-1:0]         carry_reg, carry_next;
    logic [ACC_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [DIGIT_W+CARRY_W-1:0] total;

    // The three-operand digit sum never carries more than two.
    always_comb
    begin
        total = (DIGIT_W+CARRY_W)'(sum_reg[DIGIT_W-1:0])
              + (DIGIT_W+CARRY_W)'(a_reg[DIGIT_W-1:0])
              + (DIGIT_W+CARRY_W)'(b_reg[DIGIT_W-1:0])
              + (DIGIT_W+CARRY_W)'(carry_reg);
    end

    always_comb
    begin
        sum_next   = sum_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.clear)
        begin
            sum_next  = '0;
            busy_next = 1'b0;
        end
        else if (ctrl.start)
        begin
            a_next = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
            if (ctrl.subtract)
            begin
                b_next     = ~{{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
                carry_next = CARRY_W'(1);
            end
            else
            begin
                b_next     = '0;
                carry_next = '0;
            end
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sum_next   = {total[DIGIT_W-1:0], sum_reg[SUM_W-1:DIGIT_W]};
            a_next     = a_reg >> DIGIT_W;
            b_next     = b_reg >> DIGIT_W;
            carry_next = total[DIGIT_W+CARRY_W-1:DIGIT_W];
            if (cnt_reg == ACC_CNT_W'(DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + ACC_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            carry_reg <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            carry_reg <= carry_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign sum       = sum_reg;

endmodule

[design/maf_div.sv]
// Bit-serial restoring divider of the signed sum by the window, saturated.
module maf_div #(
    parameter int DIVISOR_W = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [maf_pkg::SUM_W-1:0] sum,
    input  logic [DIVISOR_W-1:0]      divisor,
    output maf_pkg::unit_stat_t       stat,
    output logic [maf_pkg::AVG_W-1:0] quotient
);

    import maf_pkg::*;

    logic [SUM_W-1:0]     q_reg, q_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   rem_sh;
    logic [DIVISOR_W:0]   diff;
    logic                 take;
    logic                 hi_any;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb
    begin
        rem_sh = {rem_reg, q_reg[SUM_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        take   = (rem_sh >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            neg_next  = sum[SUM_W-1];
            q_next    = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = take ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            q_next   = {q_reg[SUM_W-2:0], take};
            if (cnt_reg == DIV_CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Apply the sign and clamp the magnitude to the 32-bit range.
    always_comb
    begin
        hi_any = |q_reg[SUM_W-1:AVG_W];
        if (neg_reg)
        begin
            if (hi_any || (q_reg[AVG_W-1] && (|q_reg[AVG_W-2:0])))
            begin
                quotient = AVG_MIN;
            end
            else
            begin
                quotient = ~q_reg[AVG_W-1:0] + AVG_W'(1);
            end
        end
        else
        begin
            if (hi_any || q_reg[AVG_W-1])
            begin
                quotient = AVG_MAX;
            end
            else
            begin
                quotient = q_reg[AVG_W-1:0];
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[design/moving_average_filter_top.sv]
// Top level of the windowed moving average filter over signed Q16.16 samples.
//
// This block keeps the last window_length samples in a history RAM together with
// their 40-bit running sum, and answers every item with one result: the sum
// divided by the window, truncated toward zero and clamped to 32 bits, plus the
// raw sum. The divisor is always the full window, even while the history is
// still filling. A window register of zero acts as one, and a value above
// WINDOW_MAX acts as WINDOW_MAX. A clear item, or any write of the window
// register, empties the history and zeroes the sum; a clear item answers with
// zeros. A push item loads its result into the output register through these
// steps after the edge that accepts it: the retired sample is read from the
// history RAM, the 4-bit digit-serial adder updates the running sum, the sum
// is handed to the divider, the bit-serial divider runs (one quotient bit per
// cycle), the end of the division is seen, and the output register is loaded.
// A clear item goes straight to loading its result. The load waits while the
// previous result is still stalled in the output register. The next item is
// accepted as soon as the result sits in the output register, even while that
// result still waits to be taken. There is no clearing pass after reset: the
// fill count ensures that only samples written since the last clear are ever
// read back.
// The window register must only be written while the block is idle.
module moving_average_filter_top #(
    parameter int WINDOW_MAX = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [maf_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic                                kind,
    input  logic signed [maf_pkg::SAMPLE_W-1:0] sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [maf_pkg::AVG_W-1:0]    average,
    output logic signed [maf_pkg::SUM_W-1:0]    window_sum
);

    import maf_pkg::*;

    // Ring pointer and window widths follow WINDOW_MAX; comparisons also span CFG_W.
    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int WIN_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (WIN_W > CFG_W) ? WIN_W : CFG_W;
    localparam int IDX_W = PTR_W + 2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_ADD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   cfg_reg, cfg_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [WIN_W-1:0]   fill_reg, fill_next;
    logic               sub_reg, sub_next;
    logic               zero_reg, zero_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic               rv_reg, rv_next;
    logic [AVG_W-1:0]   avg_reg, avg_next;
    logic [SUM_W-1:0]   sum_out_reg, sum_out_next;

    logic [CMP_W-1:0]   w_ext;
    logic [WIN_W-1:0]   w_eff;
    logic [IDX_W-1:0]   idx_sum;
    logic [IDX_W-1:0]   idx_wrap;
    logic [PTR_W-1:0]   rd_addr;
    logic               accept;
    logic               push;
    logic               clear_item;
    logic               out_free;
    logic [SAMPLE_W-1:0] old_sample;
    acc_ctrl_t          acc_ctrl;
    unit_stat_t         acc_stat;
    unit_stat_t         div_stat;
    logic [SUM_W-1:0]   acc_sum;
    logic               div_start;
    logic [AVG_W-1:0]   div_quot;

    // Window in force: zero behaves as one, large values clamp to the ring depth.
    always_comb
    begin
        w_ext = CMP_W'(cfg_reg);
        if (cfg_reg == '0)
        begin
            w_eff = WIN_W'(1);
        end
        else if (w_ext > CMP_W'(WINDOW_MAX))
        begin
            w_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            w_eff = w_ext[WIN_W-1:0];
        end
    end

    // The retired sample sits exactly one window behind the write pointer.
    always_comb
    begin
        idx_sum = IDX_W'(wp_reg) + IDX_W'(WINDOW_MAX) - IDX_W'(w_eff);
        if (idx_sum >= IDX_W'(WINDOW_MAX))
        begin
            idx_wrap = idx_sum - IDX_W'(WINDOW_MAX);
        end
        else
        begin
            idx_wrap = idx_sum;
        end
        rd_addr = idx_wrap[PTR_W-1:0];
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign push         = accept && (kind == KIND_PUSH);
    assign clear_item   = accept && (kind == KIND_CLEAR);
    assign out_free     = !rv_reg || !result_stall;

    always_comb
    begin
        state_next   = state_reg;
        cfg_next     = cfg_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        sub_next     = sub_reg;
        zero_next    = zero_reg;
        smp_next     = smp_reg;
        avg_next     = avg_reg;
        sum_out_next = sum_out_reg;
        rv_next      = rv_reg && result_stall;

        acc_ctrl.start    = 1'b0;
        acc_ctrl.clear    = cfg_we || clear_item;
        acc_ctrl.subtract = sub_reg;
        div_start         = 1'b0;

        if (cfg_we)
        begin
            cfg_next  = cfg_wdata;
            wp_next   = '0;
            fill_next = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (clear_item)
                begin
                    wp_next    = '0;
                    fill_next  = '0;
                    zero_next  = 1'b1;
                    state_next = S_OUT;
                end
                else if (push)
                begin
                    smp_next  = sample;
                    zero_next = 1'b0;
                    sub_next  = (fill_reg >= w_eff);
                    if (fill_reg < w_eff)
                    begin
                        fill_next = fill_reg + WIN_W'(1);
                    end
                    if (wp_reg == PTR_W'(WINDOW_MAX - 1))
                    begin
                        wp_next = '0;
                    end
                    else
                    begin
                        wp_next = wp_reg + PTR_W'(1);
                    end
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // The retired sample arrives from the RAM in this cycle.
                acc_ctrl.start = 1'b1;
                state_next     = S_ADD;
            end
            S_ADD:
            begin
                if (acc_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    avg_next     = zero_reg ? '0 : div_quot;
                    sum_out_next = acc_sum;
                    rv_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg   <= CFG_W'(1);
            wp_reg    <= '0;
            fill_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cfg_reg   <= cfg_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg     <= sub_next;
        zero_reg    <= zero_next;
        smp_reg     <= smp_next;
        avg_reg     <= avg_next;
        sum_out_reg <= sum_out_next;
    end

    maf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_history (
        .clk   (clk),
        .we    (push),
        .waddr (wp_reg),
        .wdata (sample),
        .raddr (rd_addr),
        .rdata (old_sample)
    );

    maf_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (acc_ctrl),
        .sample     (smp_reg),
        .old_sample (old_sample),
        .stat       (acc_stat),
        .sum        (acc_sum)
    );

    maf_div #(
        .DIVISOR_W (WIN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (acc_sum),
        .divisor  (w_eff),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign result_valid = rv_reg;
    assign average      = avg_reg;
    assign window_sum   = sum_out_reg;

    // The number of held samples never exceeds the window in force.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= w_eff)
        else $error("fill count exceeds the window");

    // A finished sum update hands over to a running divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD && acc_stat.done) |=> (state_reg == S_DIV && div_stat.busy))
        else $error("divider did not start after the sum update");

    // An accepted push goes straight to the history read.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (state_reg == S_READ))
        else $error("push item did not start the history read");

    // Loading a result always presents it on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (result_valid && state_reg == S_IDLE))
        else $error("result was not presented");

endmodule
